FILE: sv/octant_line_rasterizer_assert.svh
// Assertion macros for the octant line rasterizer.
// Expects i_clk and i_rst_n in the scope of use.
`ifndef OCTANT_LINE_RASTERIZER_ASSERT_SVH
`define OCTANT_LINE_RASTERIZER_ASSERT_SVH

// same-cycle implication
`define OLR_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define OLR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/olr_pkg.sv
// Shared types and constants for the octant line rasterizer.
// No dependencies.
package olr_pkg;

    typedef enum logic [2:0] {
        ZONE_0 = 3'd0,
        ZONE_1 = 3'd1,
        ZONE_2 = 3'd2,
        ZONE_3 = 3'd3,
        ZONE_4 = 3'd4,
        ZONE_5 = 3'd5,
        ZONE_6 = 3'd6,
        ZONE_7 = 3'd7
    } t_zone;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_STEP = 1'b1;

endpackage

FILE: sv/olr_engine.sv
// Line setup, canonical stepping state and pixel mapping.
// Depends on olr_pkg.
module olr_engine #(
    parameter int COORD_BITS = 12
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_fire,
    input  logic                         i_mode,
    input  logic signed [COORD_BITS-1:0] i_start_x,
    input  logic signed [COORD_BITS-1:0] i_start_y,
    input  logic signed [COORD_BITS-1:0] i_end_x,
    input  logic signed [COORD_BITS-1:0] i_end_y,
    output logic                         o_has,
    output logic signed [COORD_BITS-1:0] o_px,
    output logic signed [COORD_BITS-1:0] o_py,
    output olr_pkg::t_zone               o_zone,
    output logic                         o_last,
    output logic                         o_busy
);

    localparam int CW = COORD_BITS + 1;
    localparam int IW = COORD_BITS + 3;
    localparam int DW = COORD_BITS + 4;

    function automatic logic [2*CW-1:0] f_to_canon(olr_pkg::t_zone z,
                                                   logic signed [CW-1:0] x,
                                                   logic signed [CW-1:0] y);
        logic signed [CW-1:0] cx;
        logic signed [CW-1:0] cy;
        unique case (z)
            olr_pkg::ZONE_0: begin cx = -y; cy = -x; end
            olr_pkg::ZONE_1: begin cx = -x; cy = -y; end
            olr_pkg::ZONE_2: begin cx = x;  cy = -y; end
            olr_pkg::ZONE_3: begin cx = -y; cy = x;  end
            olr_pkg::ZONE_4: begin cx = y;  cy = x;  end
            olr_pkg::ZONE_5: begin cx = x;  cy = y;  end
            olr_pkg::ZONE_6: begin cx = -x; cy = y;  end
            olr_pkg::ZONE_7: begin cx = y;  cy = -x; end
        endcase
        return {cx, cy};
    endfunction

    function automatic logic [2*CW-1:0] f_from_canon(olr_pkg::t_zone z,
                                                     logic signed [CW-1:0] cx,
                                                     logic signed [CW-1:0] cy);
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        unique case (z)
            olr_pkg::ZONE_0: begin x = -cy; y = -cx; end
            olr_pkg::ZONE_1: begin x = -cx; y = -cy; end
            olr_pkg::ZONE_2: begin x = cx;  y = -cy; end
            olr_pkg::ZONE_3: begin x = cy;  y = -cx; end
            olr_pkg::ZONE_4: begin x = cy;  y = cx;  end
            olr_pkg::ZONE_5: begin x = cx;  y = cy;  end
            olr_pkg::ZONE_6: begin x = -cx; y = cy;  end
            olr_pkg::ZONE_7: begin x = -cy; y = cx;  end
        endcase
        return {x, y};
    endfunction

    logic signed [CW-1:0] r_cx, r_cy, r_cey;
    logic signed [DW-1:0] r_dec;
    logic signed [IW-1:0] r_sinc, r_dinc;
    olr_pkg::t_zone       r_zone;
    logic                 r_busy;

    logic signed [CW-1:0] n_cx, n_cy, n_cey;
    logic signed [DW-1:0] n_dec;
    logic signed [IW-1:0] n_sinc, n_dinc;
    olr_pkg::t_zone       n_zone;
    logic                 n_busy;

    // load setup
    logic signed [CW-1:0] w_x0, w_y0, w_x1, w_y1, w_dx, w_dy;
    logic        [CW-1:0] w_ax, w_ay;
    logic                 w_flat;
    olr_pkg::t_zone       w_zone;
    logic signed [CW-1:0] w_scx, w_scy, w_ecy, w_cdx, w_cdy;
    logic signed [IW-1:0] w_cdx_i, w_cdy_i;
    logic [2*CW-1:0]      w_sc, w_ec, w_cd;

    // advance
    logic signed [CW-1:0] w_step_x, w_step_y;
    logic                 w_dec_pos;
    logic [2*CW-1:0]      w_orig;

    assign w_x0 = {i_start_x[COORD_BITS-1], i_start_x};
    assign w_y0 = {i_start_y[COORD_BITS-1], i_start_y};
    assign w_x1 = {i_end_x[COORD_BITS-1], i_end_x};
    assign w_y1 = {i_end_y[COORD_BITS-1], i_end_y};
    assign w_dx = w_x1 - w_x0;
    assign w_dy = w_y1 - w_y0;
    assign w_ax = w_dx[CW-1] ? -w_dx : w_dx;
    assign w_ay = w_dy[CW-1] ? -w_dy : w_dy;
    assign w_flat = (w_ax >= w_ay);

    always_comb begin
        unique case ({w_dx[CW-1], w_dy[CW-1]})
            2'b00: w_zone = w_flat ? olr_pkg::ZONE_0 : olr_pkg::ZONE_1;
            2'b10: w_zone = w_flat ? olr_pkg::ZONE_3 : olr_pkg::ZONE_2;
            2'b11: w_zone = w_flat ? olr_pkg::ZONE_4 : olr_pkg::ZONE_5;
            2'b01: w_zone = w_flat ? olr_pkg::ZONE_7 : olr_pkg::ZONE_6;
        endcase
    end

    assign w_sc = f_to_canon(w_zone, w_x0, w_y0);
    assign w_ec = f_to_canon(w_zone, w_x1, w_y1);
    assign w_cd = f_to_canon(w_zone, w_dx, w_dy);
    assign w_scx = w_sc[2*CW-1:CW];
    assign w_scy = w_sc[CW-1:0];
    assign w_ecy = w_ec[CW-1:0];
    assign w_cdx = w_cd[2*CW-1:CW];
    assign w_cdy = w_cd[CW-1:0];
    assign w_cdx_i = IW'(w_cdx);
    assign w_cdy_i = IW'(w_cdy);

    assign w_dec_pos = !r_dec[DW-1] && (r_dec != '0);
    assign w_step_y  = r_cy - CW'(1);
    assign w_step_x  = w_dec_pos ? r_cx : r_cx - CW'(1);
    assign w_orig    = f_from_canon(r_zone, w_step_x, w_step_y);

    always_comb begin
        n_cx   = r_cx;
        n_cy   = r_cy;
        n_cey  = r_cey;
        n_dec  = r_dec;
        n_sinc = r_sinc;
        n_dinc = r_dinc;
        n_zone = r_zone;
        n_busy = r_busy;
        o_has  = 1'b0;
        o_px   = i_start_x;
        o_py   = i_start_y;
        o_zone = w_zone;
        o_last = 1'b0;
        if (i_mode == olr_pkg::MODE_LOAD) begin
            n_cx   = w_scx;
            n_cy   = w_scy;
            n_cey  = w_ecy;
            n_sinc = w_cdx_i <<< 1;
            n_dinc = (w_cdx_i - w_cdy_i) <<< 1;
            n_dec  = DW'(w_cdx_i <<< 1) - DW'(w_cdy);
            n_zone = w_zone;
            o_has  = 1'b1;
            o_last = (w_scy <= w_ecy);
            n_busy = !o_last;
        end else if (r_busy) begin
            n_cx   = w_step_x;
            n_cy   = w_step_y;
            n_dec  = r_dec + (w_dec_pos ? DW'(r_sinc) : DW'(r_dinc));
            o_has  = 1'b1;
            o_px   = w_orig[CW+COORD_BITS-1:CW];
            o_py   = w_orig[COORD_BITS-1:0];
            o_zone = r_zone;
            o_last = (w_step_y <= r_cey);
            n_busy = !o_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx   <= '0;
            r_cy   <= '0;
            r_cey  <= '0;
            r_dec  <= '0;
            r_sinc <= '0;
            r_dinc <= '0;
            r_zone <= olr_pkg::ZONE_0;
            r_busy <= 1'b0;
        end else if (i_fire) begin
            r_cx   <= n_cx;
            r_cy   <= n_cy;
            r_cey  <= n_cey;
            r_dec  <= n_dec;
            r_sinc <= n_sinc;
            r_dinc <= n_dinc;
            r_zone <= n_zone;
            r_busy <= n_busy;
        end
    end

    assign o_busy = r_busy;

endmodule

FILE: sv/octant_line_rasterizer.sv
// Octant line rasterizer, top level: input register, stepping engine, output register.
// Depends on olr_pkg, olr_engine and octant_line_rasterizer_assert.svh.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) takes a transaction with i_mode.
//   Mode load brings start and end points and yields the line's first pixel.
//   Mode step yields the next pixel of the current line; a step with no line
//   in progress yields nothing. A load always replaces the current line.
//   Output channel (o_out_valid / i_out_stall) returns pixel x/y, the octant
//   and a flag on the line's end point.
//   Path: the transaction is held in the input register, then one pass of
//   setup or step logic writes the result into the output register.
//   Throughput: one transaction per cycle while the output is not stalled;
//   setup and each step are one add/compare/mux pass.
//   Stall: while the output register is full and stalled, the held input
//   transaction waits and o_in_stall is raised; one transaction is buffered.
//   Reset: synchronous, active low; clears both valid flags and drops any line.
`include "octant_line_rasterizer_assert.svh"

module octant_line_rasterizer #(
    parameter int COORD_BITS = 12
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic                         i_mode,
    input  logic signed [COORD_BITS-1:0] i_start_x,
    input  logic signed [COORD_BITS-1:0] i_start_y,
    input  logic signed [COORD_BITS-1:0] i_end_x,
    input  logic signed [COORD_BITS-1:0] i_end_y,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic signed [COORD_BITS-1:0] o_pixel_x,
    output logic signed [COORD_BITS-1:0] o_pixel_y,
    output logic [2:0]                   o_octant,
    output logic                         o_last_pixel
);

    logic                         r_in_vld;
    logic                         r_mode;
    logic signed [COORD_BITS-1:0] r_sx, r_sy, r_ex, r_ey;

    logic                         r_out_vld;
    logic signed [COORD_BITS-1:0] r_px, r_py;
    olr_pkg::t_zone               r_zone;
    logic                         r_last;

    logic                         w_adv;
    logic                         w_fire;
    logic                         w_res_has;
    logic signed [COORD_BITS-1:0] w_res_px, w_res_py;
    olr_pkg::t_zone               w_res_zone;
    logic                         w_res_last;
    logic                         w_busy;

    assign w_adv      = !r_out_vld || !i_out_stall;
    assign w_fire     = r_in_vld && w_adv;
    assign o_in_stall = r_in_vld && !w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_mode <= i_mode;
            r_sx   <= i_start_x;
            r_sy   <= i_start_y;
            r_ex   <= i_end_x;
            r_ey   <= i_end_y;
        end
    end

    olr_engine #(
        .COORD_BITS (COORD_BITS)
    ) u_engine (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (w_fire),
        .i_mode    (r_mode),
        .i_start_x (r_sx),
        .i_start_y (r_sy),
        .i_end_x   (r_ex),
        .i_end_y   (r_ey),
        .o_has     (w_res_has),
        .o_px      (w_res_px),
        .o_py      (w_res_py),
        .o_zone    (w_res_zone),
        .o_last    (w_res_last),
        .o_busy    (w_busy)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= w_fire && w_res_has;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && w_res_has) begin
            r_px   <= w_res_px;
            r_py   <= w_res_py;
            r_zone <= w_res_zone;
            r_last <= w_res_last;
        end
    end

    assign o_out_valid  = r_out_vld;
    assign o_pixel_x    = r_px;
    assign o_pixel_y    = r_py;
    assign o_octant     = r_zone;
    assign o_last_pixel = r_last;

    `OLR_ASSERT_SAME(a_stall_has_item, o_in_stall, r_in_vld, "stall with no held transaction")
    `OLR_ASSERT_SAME(a_out_from_fire, $rose(r_out_vld), $past(w_fire), "output with no input")
    `OLR_ASSERT_SAME(a_no_fire_blocked, o_out_valid && i_out_stall, !w_fire, "fire when blocked")
    `OLR_ASSERT_NEXT(a_last_idles, w_fire && w_res_has && w_res_last, !w_busy, "busy after last")

endmodule

FILE: test/olr_checker.sv
// Checker for the octant line rasterizer: watches both channels, predicts each pixel
// and compares it field by field against the output transaction.
// Depends on olr_pkg.
module olr_checker #(
    parameter int COORD_BITS = 12
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic                         i_in_stall,
    input  logic                         i_mode,
    input  logic signed [COORD_BITS-1:0] i_start_x,
    input  logic signed [COORD_BITS-1:0] i_start_y,
    input  logic signed [COORD_BITS-1:0] i_end_x,
    input  logic signed [COORD_BITS-1:0] i_end_y,
    input  logic                         i_out_valid,
    input  logic                         i_out_stall,
    input  logic signed [COORD_BITS-1:0] i_pixel_x,
    input  logic signed [COORD_BITS-1:0] i_pixel_y,
    input  logic [2:0]                   i_octant,
    input  logic                         i_last_pixel,
    output int                           o_mismatches,
    output int                           o_pixels_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [COORD_BITS-1:0] t_coord;

    typedef struct {
        t_coord         x;
        t_coord         y;
        olr_pkg::t_zone zone;
        logic           last;
    } t_pixel;

    t_pixel expected_pixels[$];

    // line state, folded into zone 5 (steep, x and y falling)
    int             cur_x;
    int             cur_y;
    int             stop_y;
    int             decision_var;
    int             step_straight;
    int             step_diag;
    olr_pkg::t_zone zone;
    logic           line_active;

    function automatic olr_pkg::t_zone zone_of(int dx, int dy);
        int   ax;
        int   ay;
        logic flat;
        ax   = (dx < 0) ? -dx : dx;
        ay   = (dy < 0) ? -dy : dy;
        flat = (ax >= ay);
        if (dx >= 0 && dy >= 0) return flat ? olr_pkg::ZONE_0 : olr_pkg::ZONE_1;
        if (dx < 0 && dy >= 0) return flat ? olr_pkg::ZONE_3 : olr_pkg::ZONE_2;
        if (dx < 0) return flat ? olr_pkg::ZONE_4 : olr_pkg::ZONE_5;
        return flat ? olr_pkg::ZONE_7 : olr_pkg::ZONE_6;
    endfunction

    function automatic void fold_point(olr_pkg::t_zone z, int x, int y,
                                       output int cx, output int cy);
        case (z)
            olr_pkg::ZONE_0: begin cx = -y; cy = -x; end
            olr_pkg::ZONE_1: begin cx = -x; cy = -y; end
            olr_pkg::ZONE_2: begin cx = x;  cy = -y; end
            olr_pkg::ZONE_3: begin cx = -y; cy = x;  end
            olr_pkg::ZONE_4: begin cx = y;  cy = x;  end
            olr_pkg::ZONE_5: begin cx = x;  cy = y;  end
            olr_pkg::ZONE_6: begin cx = -x; cy = y;  end
            default: begin cx = y; cy = -x; end
        endcase
    endfunction

    function automatic void unfold_point(olr_pkg::t_zone z, int cx, int cy,
                                         output int x, output int y);
        case (z)
            olr_pkg::ZONE_0: begin x = -cy; y = -cx; end
            olr_pkg::ZONE_1: begin x = -cx; y = -cy; end
            olr_pkg::ZONE_2: begin x = cx;  y = -cy; end
            olr_pkg::ZONE_3: begin x = cy;  y = -cx; end
            olr_pkg::ZONE_4: begin x = cy;  y = cx;  end
            olr_pkg::ZONE_5: begin x = cx;  y = cy;  end
            olr_pkg::ZONE_6: begin x = -cx; y = cy;  end
            default: begin x = -cy; y = cx; end
        endcase
    endfunction

    function automatic void queue_current_pixel();
        t_pixel px;
        int     ox;
        int     oy;
        unfold_point(zone, cur_x, cur_y, ox, oy);
        px.x        = t_coord'(ox);
        px.y        = t_coord'(oy);
        px.zone     = zone;
        px.last     = (cur_y <= stop_y);
        line_active = !px.last;
        expected_pixels.push_back(px);
    endfunction

    function automatic void rasterize(logic mode, t_coord sx, t_coord sy, t_coord ex,
                                      t_coord ey);
        int fx;
        int fy;
        int gx;
        int gy;
        int cdx;
        int cdy;
        if (mode == olr_pkg::MODE_LOAD) begin
            zone = zone_of(int'(ex) - int'(sx), int'(ey) - int'(sy));
            fold_point(zone, int'(sx), int'(sy), fx, fy);
            fold_point(zone, int'(ex), int'(ey), gx, gy);
            cdx           = gx - fx;
            cdy           = gy - fy;
            cur_x         = fx;
            cur_y         = fy;
            stop_y        = gy;
            decision_var  = 2 * cdx - cdy;
            step_straight = 2 * cdx;
            step_diag     = 2 * (cdx - cdy);
            queue_current_pixel();
        end else if (line_active) begin
            cur_y = cur_y - 1;
            // zero counts as a diagonal move
            if (decision_var > 0) begin
                decision_var = decision_var + step_straight;
            end else begin
                decision_var = decision_var + step_diag;
                cur_x        = cur_x - 1;
            end
            queue_current_pixel();
        end
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            o_mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_pixel want;
        if (!i_rst_n) begin
            expected_pixels.delete();
            cur_x         = 0;
            cur_y         = 0;
            stop_y        = 0;
            decision_var  = 0;
            step_straight = 0;
            step_diag     = 0;
            zone          = olr_pkg::ZONE_0;
            line_active   = 1'b0;
            o_mismatches  = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_pixels.size() == 0) begin
                    $display("%0t ns: unexpected pixel, expected none, actual x=%0d y=%0d",
                             $time, i_pixel_x, i_pixel_y);
                    o_mismatches++;
                end else begin
                    want = expected_pixels.pop_front();
                    check_field("pixel_x", int'(want.x), int'(i_pixel_x));
                    check_field("pixel_y", int'(want.y), int'(i_pixel_y));
                    check_field("octant", int'(want.zone), int'(i_octant));
                    check_field("last_pixel", int'(want.last), int'(i_last_pixel));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                rasterize(i_mode, i_start_x, i_start_y, i_end_x, i_end_y);
            end
        end
        o_pixels_pending = expected_pixels.size();
    end

endmodule

FILE: test/tb_top.sv
// Testbench top for the octant line rasterizer: clock, reset, line stimulus and verdict.
// Depends on olr_pkg, octant_line_rasterizer and olr_checker.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COORD_BITS     = 12;
    localparam int RANDOM_ITEMS   = 450;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;

    typedef logic signed [COORD_BITS-1:0] t_coord;

    logic   clk       = 1'b0;
    logic   rst_n     = 1'b0;
    logic   in_valid  = 1'b0;
    logic   mode      = olr_pkg::MODE_LOAD;
    t_coord start_x   = '0;
    t_coord start_y   = '0;
    t_coord end_x     = '0;
    t_coord end_y     = '0;
    logic   out_stall = 1'b0;
    logic   quiet     = 1'b0;

    logic       in_stall;
    logic       out_valid;
    t_coord     pixel_x;
    t_coord     pixel_y;
    logic [2:0] octant;
    logic       last_pixel;
    int         mismatches;
    int         pixels_pending;
    int         idle_cycles = 0;

    octant_line_rasterizer #(
        .COORD_BITS(COORD_BITS)
    ) u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_mode      (mode),
        .i_start_x   (start_x),
        .i_start_y   (start_y),
        .i_end_x     (end_x),
        .i_end_y     (end_y),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_pixel_x   (pixel_x),
        .o_pixel_y   (pixel_y),
        .o_octant    (octant),
        .o_last_pixel(last_pixel)
    );

    olr_checker #(
        .COORD_BITS(COORD_BITS)
    ) u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_stall      (in_stall),
        .i_mode          (mode),
        .i_start_x       (start_x),
        .i_start_y       (start_y),
        .i_end_x         (end_x),
        .i_end_y         (end_y),
        .i_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .i_pixel_x       (pixel_x),
        .i_pixel_y       (pixel_y),
        .i_octant        (octant),
        .i_last_pixel    (last_pixel),
        .o_mismatches    (mismatches),
        .o_pixels_pending(pixels_pending)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk) begin
        out_stall <= !quiet && ($urandom_range(99) < 14);
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic int any_coord();
        return int'(t_coord'($urandom));
    endfunction

    function automatic int clamp_coord(int v);
        if (v < -(1 << (COORD_BITS-1))) return -(1 << (COORD_BITS-1));
        if (v > (1 << (COORD_BITS-1)) - 1) return (1 << (COORD_BITS-1)) - 1;
        return v;
    endfunction

    function automatic int line_steps(int sx, int sy, int ex, int ey);
        int dx;
        int dy;
        dx = ex - sx;
        dy = ey - sy;
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        return (dx > dy) ? dx : dy;
    endfunction

    task automatic send_item(logic m, int sx, int sy, int ex, int ey);
        while (!quiet && $urandom_range(99) < 14) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        mode     <= m;
        start_x  <= t_coord'(sx);
        start_y  <= t_coord'(sy);
        end_x    <= t_coord'(ex);
        end_y    <= t_coord'(ey);
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic trace_line(int sx, int sy, int ex, int ey, int advances);
        send_item(olr_pkg::MODE_LOAD, sx, sy, ex, ey);
        repeat (advances) begin
            send_item(olr_pkg::MODE_STEP, any_coord(), any_coord(), any_coord(), any_coord());
        end
    endtask

    task automatic run_directed();
        // advance with no line, then single-pixel lines at both corners
        send_item(olr_pkg::MODE_STEP, 2047, -2048, -1, 0);
        trace_line(-2048, -2048, -2048, -2048, 1);
        trace_line(2047, 2047, 2047, 2047, 0);
        // one line per zone, corner to corner for zones 4 and 7; some are cut off by the next load
        trace_line(-2048, -2048, -2046, -2047, 2);
        trace_line(0, 0, 1, 2, 2);
        trace_line(2047, 0, 2046, 2, 1);
        trace_line(2047, -2048, 2045, -2047, 2);
        trace_line(2047, 2047, -2048, -2048, 1);
        trace_line(0, 0, -1, -2, 2);
        trace_line(-2048, 2047, -2047, 2045, 2);
        trace_line(-2048, 2047, 2047, -2048, 2);
    endtask

    task automatic run_random();
        int counted;
        int pick;
        int span;
        int steps;
        int advances;
        int sx;
        int sy;
        int ex;
        int ey;
        counted = 0;
        while (counted < RANDOM_ITEMS) begin
            quiet <= (counted >= 150 && counted < 260);
            pick = $urandom_range(99);
            if (pick < 6) begin
                send_item(olr_pkg::MODE_STEP, any_coord(), any_coord(), any_coord(),
                          any_coord());
                counted += 1;
            end else begin
                sx = any_coord();
                sy = any_coord();
                if (pick < 12) begin
                    ex = any_coord();
                    ey = any_coord();
                end else begin
                    span = (pick < 50) ? 3 : (pick < 85) ? 12 : 40;
                    ex   = clamp_coord(sx + int'($urandom_range(0, 2 * span)) - span);
                    ey   = clamp_coord(sy + int'($urandom_range(0, 2 * span)) - span);
                end
                steps = line_steps(sx, sy, ex, ey);
                pick  = $urandom_range(99);
                if (pick < 15) advances = $urandom_range(0, steps);
                else if (pick < 25) advances = steps + $urandom_range(1, 3);
                else advances = steps;
                // long lines are cut short
                if (advances > 300) advances = $urandom_range(0, 300);
                if (advances > RANDOM_ITEMS - counted - 1) advances = RANDOM_ITEMS - counted - 1;
                trace_line(sx, sy, ex, ey, advances);
                counted += 1 + advances;
            end
        end
        quiet <= 1'b0;
    endtask

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        run_random();
        in_valid <= 1'b0;
        do @(negedge clk); while (pixels_pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+sv
sv/olr_pkg.sv
sv/olr_engine.sv
sv/octant_line_rasterizer.sv
test/olr_checker.sv
test/tb_top.sv
